### hdl/hsbp_pkg.sv
// ----------------------------------------------------------------------------
// hsbp_pkg
// Shared types and constants for the hue/saturation back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsbp_pkg;

	// Default histogram geometry.
	localparam int HUE_BINS_DEF = 60;
	localparam int SAT_BINS_DEF = 64;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Hue is divided by three as (hue * 171) >> 9, exact for any 8-bit hue.
	localparam int DIV3_MUL   = 171;
	localparam int DIV3_SHIFT = 9;

	// Accumulator and coordinate widths.
	localparam int SUM_W     = 34;
	localparam int CNT_W     = 23;
	localparam int COORD_W   = 11;
	localparam int DIM_W     = 12;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	// Register reset values and frame size limit.
	localparam logic [7:0]       THRESHOLD_RST = 8'd128;
	localparam logic [DIM_W-1:0] WIDTH_RST     = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST    = 12'd480;
	localparam logic [DIM_W-1:0] MAX_DIM       = 12'd2048;

	// Input command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_THRESHOLD    = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	// Request to the centroid divider.
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic [CNT_W-1:0] count;
	} div_req_t;

	// Divider result: quotients truncated to coordinate width.
	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] quot_x;
		logic [COORD_W-1:0] quot_y;
	} div_res_t;

endpackage

`default_nettype wire

### hdl/hsbp_fifo.sv
// ----------------------------------------------------------------------------
// hsbp_fifo
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module hsbp_fifo #(
	parameter int DEPTH = hsbp_pkg::QUEUE_DEPTH,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Storage; no reset is needed on the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/hsbp_front.sv
// ----------------------------------------------------------------------------
// hsbp_front
// Accepts input items, turns pixels and loads into table addresses and
// queues them for the back part. Loads outside the table are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module hsbp_front #(
	parameter int HUE_BINS = hsbp_pkg::HUE_BINS_DEF,
	parameter int SAT_BINS = hsbp_pkg::SAT_BINS_DEF
) (
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic       command,
	input  wire logic [7:0] hue,
	input  wire logic [7:0] saturation,
	input  wire logic [5:0] bin_hue,
	input  wire logic [5:0] bin_sat,
	input  wire logic [7:0] bin_weight,
	input  wire logic       q_full,
	output logic            q_push,
	output logic [((HUE_BINS * SAT_BINS > 1) ? $clog2(HUE_BINS * SAT_BINS) : 1) + 8:0] q_data
);

	localparam int DEPTH = HUE_BINS * SAT_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [16:0]   hue_prod;
	logic [8:0]    hue_div;
	logic [8:0]    pix_hb;
	logic [8:0]    sat_div;
	logic [8:0]    pix_sb;
	logic [16:0]   pix_addr;
	logic [16:0]   load_addr;
	logic          load_ok;
	logic [AW-1:0] addr;

	// Pixel bins: hue over three and saturation over four, each saturating.
	always_comb begin
		hue_prod = 17'(hue) * 17'(hsbp_pkg::DIV3_MUL);
		hue_div  = 9'(hue_prod >> hsbp_pkg::DIV3_SHIFT);
		pix_hb   = (hue_div > 9'(HUE_BINS - 1)) ? 9'(HUE_BINS - 1) : hue_div;
		sat_div  = 9'(saturation >> 2);
		pix_sb   = (sat_div > 9'(SAT_BINS - 1)) ? 9'(SAT_BINS - 1) : sat_div;
		pix_addr = 17'(pix_hb) * 17'(SAT_BINS) + 17'(pix_sb);
	end

	// Load address, valid only when both bins fall inside the table.
	always_comb begin
		load_ok   = (9'(bin_hue) < 9'(HUE_BINS)) && (9'(bin_sat) < 9'(SAT_BINS));
		load_addr = 17'(bin_hue) * 17'(SAT_BINS) + 17'(bin_sat);
	end

	// Queue entry: item kind on top, then the weight, then the address.
	always_comb begin
		addr     = (command == hsbp_pkg::CMD_PIXEL) ? pix_addr[AW-1:0] : load_addr[AW-1:0];
		q_data   = {command, bin_weight, addr};
		s_tready = !q_full;
		q_push   = s_tvalid && !q_full && ((command == hsbp_pkg::CMD_PIXEL) || load_ok);
	end

endmodule

`default_nettype wire

### hdl/hsbp_div.sv
// ----------------------------------------------------------------------------
// hsbp_div
// Restoring divider, one quotient bit per cycle, dividing both coordinate
// sums by the hit count in parallel lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module hsbp_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hsbp_pkg::div_req_t req,
	output hsbp_pkg::div_res_t      res
);

	localparam int SW = hsbp_pkg::SUM_W;
	localparam int CW = hsbp_pkg::CNT_W;

	logic [SW-1:0]              dvd_x_q;
	logic [SW-1:0]              dvd_y_q;
	logic [CW-1:0]              rem_x_q;
	logic [CW-1:0]              rem_y_q;
	logic [CW-1:0]              dvs_q;
	logic [hsbp_pkg::STEP_W-1:0] step_q;
	logic                       run_q;
	logic                       done_q;
	logic [SW+CW-1:0]           lane_x;
	logic [SW+CW-1:0]           lane_y;

	// One restoring step: returns the next remainder above the next dividend.
	function automatic logic [SW+CW-1:0] div_step(input logic [CW-1:0] rem,
		input logic [SW-1:0] dvd, input logic [CW-1:0] dvs);
		logic [CW:0]   trial;
		logic [CW:0]   diff;
		logic          ge;
		logic [CW-1:0] rem_n;
		trial = {rem, dvd[SW-1]};
		diff  = trial - {1'b0, dvs};
		ge    = (trial >= {1'b0, dvs});
		rem_n = ge ? diff[CW-1:0] : trial[CW-1:0];
		return {rem_n, dvd[SW-2:0], ge};
	endfunction

	assign lane_x = div_step(rem_x_q, dvd_x_q, dvs_q);
	assign lane_y = div_step(rem_y_q, dvd_y_q, dvs_q);

	assign res.done   = done_q;
	assign res.quot_x = dvd_x_q[hsbp_pkg::COORD_W-1:0];
	assign res.quot_y = dvd_y_q[hsbp_pkg::COORD_W-1:0];

	// Operand and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_x_q <= req.sum_x;
			dvd_y_q <= req.sum_y;
			rem_x_q <= '0;
			rem_y_q <= '0;
			dvs_q   <= req.count;
		end else if (run_q) begin
			{rem_x_q, dvd_x_q} <= lane_x;
			{rem_y_q, dvd_y_q} <= lane_y;
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			step_q <= hsbp_pkg::STEP_W'(hsbp_pkg::DIV_STEPS);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == hsbp_pkg::STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/hsbp_back.sv
// ----------------------------------------------------------------------------
// hsbp_back
// Executes queued items: loads write the weight table, pixels read it,
// update the centroid sums and raster counters and produce a result item.
// ----------------------------------------------------------------------------
`default_nettype none

module hsbp_back #(
	parameter int HUE_BINS = hsbp_pkg::HUE_BINS_DEF,
	parameter int SAT_BINS = hsbp_pkg::SAT_BINS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire logic [((HUE_BINS * SAT_BINS > 1) ? $clog2(HUE_BINS * SAT_BINS) : 1) + 8:0] q_data,
	output logic                               q_pop,
	input  wire logic [7:0]                    threshold,
	input  wire logic [hsbp_pkg::DIM_W-1:0]    frame_width,
	input  wire logic [hsbp_pkg::DIM_W-1:0]    frame_height,
	output hsbp_pkg::div_req_t                 div_req,
	input  wire hsbp_pkg::div_res_t            div_res,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [31:0]                        m_tdata,
	output logic                               m_tlast
);

	localparam int DEPTH = HUE_BINS * SAT_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = hsbp_pkg::SUM_W;
	localparam int CW    = hsbp_pkg::CNT_W;
	localparam int XW    = hsbp_pkg::COORD_W;
	localparam int DW    = hsbp_pkg::DIM_W;

	logic [7:0]    bin_mem [DEPTH];

	logic [AW-1:0] q_addr;
	logic [7:0]    q_weight;
	logic          q_is_pixel;
	logic          pop_load;
	logic          pop_pixel;

	logic          pix_valid_s1;
	logic [7:0]    weight_s1;
	logic          advance_s1;
	logic          move_s1;

	logic [XW-1:0] col_q;
	logic [XW-1:0] row_q;
	logic [SW-1:0] sum_x_q;
	logic [SW-1:0] sum_y_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [7:0]    frame_weight_q;
	logic          zero_q;

	logic          out_valid_q;
	logic [7:0]    out_value_q;
	logic          out_last_q;
	logic [XW-1:0] out_cx_q;
	logic [XW-1:0] out_cy_q;
	logic          out_free;
	logic          frame_out;

	logic          hit;
	logic [SW-1:0] sum_x_nxt;
	logic [SW-1:0] sum_y_nxt;
	logic [CW-1:0] cnt_nxt;
	logic [DW-1:0] width_eff;
	logic [DW-1:0] height_eff;
	logic          row_end;
	logic          frame_end;

	// Queue entry fields and pop control.
	always_comb begin
		q_addr     = q_data[AW-1:0];
		q_weight   = q_data[AW+7:AW];
		q_is_pixel = (q_data[AW+8] == hsbp_pkg::CMD_PIXEL);
		out_free   = !out_valid_q || m_tready;
		move_s1    = pix_valid_s1 && !busy_q && out_free;
		advance_s1 = !pix_valid_s1 || move_s1;
		pop_load   = q_valid && !q_is_pixel;
		pop_pixel  = q_valid && q_is_pixel && advance_s1;
		q_pop      = pop_load || pop_pixel;
		frame_out  = busy_q && div_res.done && out_free;
	end

	// Weight table: loads write, pixels read into the first stage.
	always_ff @(posedge clk) begin
		if (pop_load) begin
			bin_mem[q_addr] <= q_weight;
		end
		if (pop_pixel) begin
			weight_s1 <= bin_mem[q_addr];
		end
	end

	// Effective frame size, zero acting as one and large values clipped.
	always_comb begin
		if (frame_width == '0) begin
			width_eff = DW'(1);
		end else if (frame_width > hsbp_pkg::MAX_DIM) begin
			width_eff = hsbp_pkg::MAX_DIM;
		end else begin
			width_eff = frame_width;
		end
		if (frame_height == '0) begin
			height_eff = DW'(1);
		end else if (frame_height > hsbp_pkg::MAX_DIM) begin
			height_eff = hsbp_pkg::MAX_DIM;
		end else begin
			height_eff = frame_height;
		end
	end

	// Threshold test, accumulation and raster position.
	always_comb begin
		hit       = (weight_s1 > threshold);
		sum_x_nxt = hit ? sum_x_q + SW'(col_q) : sum_x_q;
		sum_y_nxt = hit ? sum_y_q + SW'(row_q) : sum_y_q;
		cnt_nxt   = hit ? cnt_q + 1'b1 : cnt_q;
		row_end   = ({1'b0, col_q} + 1'b1 >= width_eff);
		frame_end = row_end && ({1'b0, row_q} + 1'b1 >= height_eff);
	end

	// Divider request on the frame's last pixel.
	always_comb begin
		div_req.start = move_s1 && frame_end;
		div_req.sum_x = sum_x_nxt;
		div_req.sum_y = sum_y_nxt;
		div_req.count = cnt_nxt;
	end

	// Control state: stage valid, counters, sums and the output flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			cnt_q        <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance_s1) begin
				pix_valid_s1 <= pop_pixel;
			end
			if (move_s1) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (frame_end) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					cnt_q   <= '0;
					busy_q  <= 1'b1;
				end else begin
					sum_x_q <= sum_x_nxt;
					sum_y_q <= sum_y_nxt;
					cnt_q   <= cnt_nxt;
				end
			end
			if (frame_out) begin
				busy_q <= 1'b0;
			end
			if ((move_s1 && !frame_end) || frame_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register and the held frame-end pixel.
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			frame_weight_q <= weight_s1;
			zero_q         <= (cnt_nxt == '0);
		end
		if (move_s1 && !frame_end) begin
			out_value_q <= weight_s1;
			out_last_q  <= 1'b0;
			out_cx_q    <= '0;
			out_cy_q    <= '0;
		end else if (frame_out) begin
			out_value_q <= frame_weight_q;
			out_last_q  <= 1'b1;
			out_cx_q    <= zero_q ? '0 : div_res.quot_x;
			out_cy_q    <= zero_q ? '0 : div_res.quot_y;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_cy_q, out_cx_q, out_value_q};

endmodule

`default_nettype wire

### hdl/hs_backproject_centroid.sv
// A pixel's result reaches m_tvalid through the queue, the table read stage and
// the output register; a load gives none. Pixels and loads are taken one per cycle,
// while the queue is not full, through the table's single read/write port.
// The frame's last pixel waits for the restoring divider, stalling the pipe behind it.
// Reset clears counters, sums and handshakes and restores the register defaults;
// the weight table is not cleared and must be loaded before pixels are sent.
// ----------------------------------------------------------------------------
// hs_backproject_centroid
// Hue/saturation histogram back-projection with a thresholded centroid.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_backproject_centroid #(
	parameter int HUE_BINS = hsbp_pkg::HUE_BINS_DEF,
	parameter int SAT_BINS = hsbp_pkg::SAT_BINS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// hue[7:0], saturation[15:8], bin_hue[21:16], bin_sat[27:22], bin_weight[35:28]
	input  wire logic [39:0] s_tdata,
	// command[0]
	input  wire logic [0:0]  s_tuser,
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// backproj_value[7:0], center_x[18:8], center_y[29:19]
	output logic [31:0]      m_tdata,
	output logic             m_tlast,
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int DEPTH = HUE_BINS * SAT_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = AW + 9;

	logic [7:0]                   threshold_q;
	logic [hsbp_pkg::DIM_W-1:0]   frame_width_q;
	logic [hsbp_pkg::DIM_W-1:0]   frame_height_q;

	logic                         q_push;
	logic [EW-1:0]                q_push_data;
	logic                         q_full;
	logic                         q_pop;
	logic                         q_valid;
	logic [EW-1:0]                q_pop_data;
	hsbp_pkg::div_req_t           div_req;
	hsbp_pkg::div_res_t           div_res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= hsbp_pkg::THRESHOLD_RST;
			frame_width_q  <= hsbp_pkg::WIDTH_RST;
			frame_height_q <= hsbp_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hsbp_pkg::REG_THRESHOLD:    threshold_q    <= cfg_data[7:0];
				hsbp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				hsbp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front part: classification and table addressing.
	hsbp_front #(
		.HUE_BINS (HUE_BINS),
		.SAT_BINS (SAT_BINS)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.command    (s_tuser[0]),
		.hue        (s_tdata[7:0]),
		.saturation (s_tdata[15:8]),
		.bin_hue    (s_tdata[21:16]),
		.bin_sat    (s_tdata[27:22]),
		.bin_weight (s_tdata[35:28]),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_push_data)
	);

	// Queue between the two parts.
	hsbp_fifo #(
		.DEPTH (hsbp_pkg::QUEUE_DEPTH),
		.WIDTH (EW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_pop_data)
	);

	// Back part: table, accumulation and results.
	hsbp_back #(
		.HUE_BINS (HUE_BINS),
		.SAT_BINS (SAT_BINS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_pop_data),
		.q_pop        (q_pop),
		.threshold    (threshold_q),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.div_req      (div_req),
		.div_res      (div_res),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

	// Centroid divider.
	hsbp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

endmodule

`default_nettype wire
